// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned PhaseCount = 13;

  typedef enum logic [PhaseCount-1:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_START_HI  = 13'b0000000000010,
    PH_START_LO  = 13'b0000000000100,
    PH_STOP_LO   = 13'b0000000001000,
    PH_STOP_HI   = 13'b0000000010000,
    PH_WR_LOW    = 13'b0000000100000,
    PH_WR_HIGH   = 13'b0000001000000,
    PH_ACK_LOW   = 13'b0000010000000,
    PH_ACK_POLL  = 13'b0000100000000,
    PH_RD_LOW    = 13'b0001000000000,
    PH_RD_HIGH   = 13'b0010000000000,
    PH_RACK_LOW  = 13'b0100000000000,
    PH_RACK_HIGH = 13'b1000000000000
  } phase_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_ACK_TIMEOUT = 2'd1
  } reg_idx_e;

  localparam logic [7:0] HalfPeriodReset = 8'd2;
  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [7:0] CountMax        = 8'hFF;
  localparam logic [3:0] BitsPerByte     = 4'd8;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    op_e        operation;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driven;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_fail;
  } res_t;

endpackage

// ===== design/i2cm_engine.sv =====
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::cmd_t cmd_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::res_t res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [3:0] bit_index_q, bit_index_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] wait_q, wait_d;
  logic       ack_choice_q, ack_choice_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic [7:0] rd_q, rd_d;
  logic       err_q, err_d;

  logic [7:0] hp;
  logic [7:0] to;
  logic [7:0] tick_inc;
  logic [7:0] wait_inc;
  logic [3:0] bit_inc;
  logic [7:0] shift_wr;
  logic [7:0] shift_rd;
  logic       half_end;
  logic       done;

  assign hp       = (cfg_i.half_period_ticks == 8'd0) ? 8'd1 : cfg_i.half_period_ticks;
  assign to       = (cfg_i.ack_timeout == 8'd0) ? 8'd1 : cfg_i.ack_timeout;
  assign tick_inc = tick_q + 8'd1;
  assign wait_inc = (wait_q == i2cm_pkg::CountMax) ? wait_q : wait_q + 8'd1;
  assign bit_inc  = bit_index_q + 4'd1;
  assign shift_wr = {shift_q[6:0], 1'b0};
  assign shift_rd = {shift_q[6:0], cmd_i.sda_in};
  assign half_end = (tick_inc >= hp);

  always_comb begin
    phase_d      = phase_q;
    bit_index_d  = bit_index_q;
    shift_d      = shift_q;
    tick_d       = tick_q;
    wait_d       = wait_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    drv_d        = drv_q;
    rd_d         = rd_q;
    err_d        = err_q;
    done         = 1'b0;

    case (phase_q)
      i2cm_pkg::PH_ACK_POLL: begin
        if (!cmd_i.sda_in) begin
          {scl_d, sda_d, drv_d} = 3'b011;
          phase_d = i2cm_pkg::PH_IDLE;
          tick_d  = 8'd0;
          done    = 1'b1;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= to) begin
            err_d = 1'b1;
            {scl_d, sda_d, drv_d} = 3'b001;
            phase_d = i2cm_pkg::PH_STOP_LO;
            tick_d  = 8'd0;
          end
        end
      end
      i2cm_pkg::PH_START_HI, i2cm_pkg::PH_START_LO, i2cm_pkg::PH_STOP_LO,
      i2cm_pkg::PH_STOP_HI, i2cm_pkg::PH_WR_LOW, i2cm_pkg::PH_WR_HIGH,
      i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_RD_LOW, i2cm_pkg::PH_RD_HIGH,
      i2cm_pkg::PH_RACK_LOW, i2cm_pkg::PH_RACK_HIGH: begin
        tick_d = half_end ? 8'd0 : tick_inc;
        if (half_end) begin
          case (phase_q)
            i2cm_pkg::PH_START_HI: begin
              {scl_d, sda_d, drv_d} = 3'b101;
              phase_d = i2cm_pkg::PH_START_LO;
            end
            i2cm_pkg::PH_START_LO: begin
              {scl_d, sda_d, drv_d} = 3'b001;
              phase_d = i2cm_pkg::PH_IDLE;
              done    = 1'b1;
            end
            i2cm_pkg::PH_STOP_LO: begin
              {scl_d, sda_d, drv_d} = 3'b111;
              phase_d = i2cm_pkg::PH_STOP_HI;
            end
            i2cm_pkg::PH_STOP_HI: begin
              phase_d = i2cm_pkg::PH_IDLE;
              done    = 1'b1;
            end
            i2cm_pkg::PH_WR_LOW: begin
              {scl_d, sda_d, drv_d} = {1'b1, sda_q, 1'b1};
              phase_d = i2cm_pkg::PH_WR_HIGH;
            end
            i2cm_pkg::PH_WR_HIGH: begin
              bit_index_d = bit_inc;
              shift_d     = shift_wr;
              if (bit_inc >= i2cm_pkg::BitsPerByte) begin
                {scl_d, sda_d, drv_d} = 3'b010;
                phase_d = i2cm_pkg::PH_ACK_LOW;
              end else begin
                {scl_d, sda_d, drv_d} = {1'b0, shift_wr[7], 1'b1};
                phase_d = i2cm_pkg::PH_WR_LOW;
              end
            end
            i2cm_pkg::PH_ACK_LOW: begin
              {scl_d, sda_d, drv_d} = 3'b110;
              wait_d  = 8'd0;
              phase_d = i2cm_pkg::PH_ACK_POLL;
            end
            i2cm_pkg::PH_RD_LOW: begin
              {scl_d, sda_d, drv_d} = 3'b110;
              phase_d = i2cm_pkg::PH_RD_HIGH;
            end
            i2cm_pkg::PH_RD_HIGH: begin
              shift_d     = shift_rd;
              bit_index_d = bit_inc;
              if (bit_inc >= i2cm_pkg::BitsPerByte) begin
                rd_d = shift_rd;
                {scl_d, sda_d, drv_d} = {1'b0, ~ack_choice_q, 1'b1};
                phase_d = i2cm_pkg::PH_RACK_LOW;
              end else begin
                {scl_d, sda_d, drv_d} = 3'b010;
                phase_d = i2cm_pkg::PH_RD_LOW;
              end
            end
            i2cm_pkg::PH_RACK_LOW: begin
              {scl_d, sda_d, drv_d} = {1'b1, sda_q, 1'b1};
              phase_d = i2cm_pkg::PH_RACK_HIGH;
            end
            default: begin
              {scl_d, sda_d, drv_d} = {1'b0, sda_q, 1'b1};
              phase_d = i2cm_pkg::PH_IDLE;
              done    = 1'b1;
            end
          endcase
        end
      end
      default: begin
        // Idle, and any corrupted phase code, accepts a new command.
        phase_d = i2cm_pkg::PH_IDLE;
        if (cmd_i.cmd_valid) begin
          bit_index_d = 4'd0;
          tick_d      = 8'd0;
          case (cmd_i.operation)
            i2cm_pkg::OP_START: begin
              {scl_d, sda_d, drv_d} = 3'b111;
              phase_d = i2cm_pkg::PH_START_HI;
            end
            i2cm_pkg::OP_STOP: begin
              {scl_d, sda_d, drv_d} = 3'b001;
              phase_d = i2cm_pkg::PH_STOP_LO;
            end
            i2cm_pkg::OP_WRITE: begin
              shift_d = cmd_i.write_byte;
              err_d   = 1'b0;
              {scl_d, sda_d, drv_d} = {1'b0, cmd_i.write_byte[7], 1'b1};
              phase_d = i2cm_pkg::PH_WR_LOW;
            end
            default: begin
              shift_d      = 8'd0;
              ack_choice_d = cmd_i.send_ack;
              {scl_d, sda_d, drv_d} = 3'b010;
              phase_d = i2cm_pkg::PH_RD_LOW;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cm_pkg::PH_IDLE;
      bit_index_q  <= 4'd0;
      shift_q      <= 8'd0;
      tick_q       <= 8'd0;
      wait_q       <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      drv_q        <= 1'b1;
      rd_q         <= 8'd0;
      err_q        <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_index_q  <= bit_index_d;
      shift_q      <= shift_d;
      tick_q       <= tick_d;
      wait_q       <= wait_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      drv_q        <= drv_d;
      rd_q         <= rd_d;
      err_q        <= err_d;
    end
  end

  always_comb begin
    res_o.scl_level  = scl_d;
    res_o.sda_level  = sda_d;
    res_o.sda_driven = drv_d;
    res_o.busy_res   = (phase_d != i2cm_pkg::PH_IDLE);
    res_o.done_res   = done;
    res_o.read_byte  = rd_d;
    res_o.ack_fail   = err_d;
  end

endmodule

// ===== design/i2cm_out_stage.sv =====
`timescale 1ns / 1ps

module i2cm_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  i2cm_pkg::res_t res_i,
  input  logic           take_i,
  output logic           valid_o,
  output i2cm_pkg::res_t res_o
);

  logic           valid_q;
  i2cm_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/i2c_master_byte_engine_unit.sv =====
`timescale 1ns / 1ps

// I2C master bit engine. Each transaction on the slave stream is one bus tick:
// it carries an optional command in tuser and the sampled SDA level in tdata.
// Every accepted tick yields exactly one result transaction on the master
// stream with the SCL/SDA levels, the SDA drive enable, busy and done flags,
// the last read byte and the acknowledge error flag.
// The result of a tick is registered and held in the output register from the
// cycle after it is accepted. One tick is accepted every cycle unless the
// receiver stalls; the engine state and output register update on acceptance.
// When the receiver stalls, the output register holds its result and
// s_axis_tready falls until that result is taken; nothing is lost.
// The configuration channel is always ready: index 0 sets the SCL half period
// in ticks, index 1 the acknowledge timeout; other indices are ignored.
// Writes should only be made while the engine is idle.
// Reset clears the engine to idle with SCL and SDA high and SDA driven, the half
// period to two ticks and the acknowledge timeout to 250 ticks.

module i2c_master_byte_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: write_byte[7:0], send_ack, sda_in, zero padding.
  input  logic [15:0] s_axis_tdata,
  // Fields from bit 0: cmd_valid, operation[1:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: scl_level, sda_level, sda_driven, busy_res, done_res,
  // read_byte[7:0], ack_fail, zero padding.
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  i2cm_pkg::cfg_t cfg_q;
  i2cm_pkg::cmd_t cmd;
  i2cm_pkg::res_t res_next;
  i2cm_pkg::res_t res_out;
  logic           accept;
  logic           out_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= i2cm_pkg::HalfPeriodReset;
      cfg_q.ack_timeout       <= i2cm_pkg::AckTimeoutReset;
    end else if (cfg_valid_i) begin
      case (i2cm_pkg::reg_idx_e'(cfg_index_i))
        i2cm_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data_i;
        i2cm_pkg::REG_ACK_TIMEOUT: cfg_q.ack_timeout       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cmd.cmd_valid  = s_axis_tuser[0];
    cmd.operation  = i2cm_pkg::op_e'(s_axis_tuser[2:1]);
    cmd.write_byte = s_axis_tdata[7:0];
    cmd.send_ack   = s_axis_tdata[8];
    cmd.sda_in     = s_axis_tdata[9];
  end

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2cm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .res_o  (res_next)
  );

  i2cm_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_next),
    .take_i  (m_axis_tready),
    .valid_o (out_valid),
    .res_o   (res_out)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, res_out.ack_fail, res_out.read_byte, res_out.done_res,
                          res_out.busy_res, res_out.sda_driven, res_out.sda_level,
                          res_out.scl_level};

endmodule
